// File: sv/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants and types for the LZW decoder with DNA base unpacking.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    // Field widths fixed by the item format.
    localparam int CODE_W = 12;
    localparam int BYTE_W = 8;
    localparam int BASE_W = 2;

    // Dictionary and string limits.
    localparam int DICT_DEPTH = 4096;
    localparam int MAX_STRING = 32;
    localparam int LITERALS   = 256;

    localparam int ADDR_W = $clog2(DICT_DEPTH);
    localparam int NFC_W  = $clog2(DICT_DEPTH + 1);
    localparam int SP_W   = $clog2(MAX_STRING + 1);
    localparam int SIDX_W = $clog2(MAX_STRING);

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Masks and shifts that split a byte into four bases, high pair first.
    localparam logic [BYTE_W-1:0] BASE0_MASK = 8'b11000000;
    localparam logic [BYTE_W-1:0] BASE1_MASK = 8'b00110000;
    localparam logic [BYTE_W-1:0] BASE2_MASK = 8'b00001100;
    localparam logic [BYTE_W-1:0] BASE3_MASK = 8'b00000011;
    localparam int BASE0_SHIFT = 6;
    localparam int BASE1_SHIFT = 4;
    localparam int BASE2_SHIFT = 2;
    localparam int BASE3_SHIFT = 0;

    // One classified input item as it travels from the front to the back.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              start;
        logic              literal;
        logic              out_of_range;
    } lzwd_item_t;

endpackage

// File: sv/lzwd_front.sv
// ----------------------------------------------------------------------------
// lzwd_front
// Input stage: accepts items, classifies the code and holds the result
// until the queue takes it.
// ----------------------------------------------------------------------------
module lzwd_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [lzwd_pkg::CODE_W-1:0] s_code,
    input  logic                       s_stream_start,
    output lzwd_pkg::lzwd_item_t       item,
    output logic                       item_valid,
    input  logic                       item_ready
);
    import lzwd_pkg::*;

    lzwd_item_t item_reg, item_next;
    logic       valid_reg, valid_next;
    logic       take;

    // The stage takes a new item whenever its held item leaves or it is empty.
    assign s_ready = !valid_reg || item_ready;
    assign take    = s_valid && s_ready;

    // Classification that does not depend on the dictionary state.
    always_comb begin
        item_next.code         = s_code;
        item_next.start        = s_stream_start;
        item_next.literal      = s_code < CODE_W'(LITERALS);
        item_next.out_of_range = 32'(s_code) >= DICT_DEPTH;
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// File: sv/lzwd_queue.sv
// ----------------------------------------------------------------------------
// lzwd_queue
// Short first-in first-out queue of classified items between the front and
// the back part.
// ----------------------------------------------------------------------------
module lzwd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lzwd_pkg::lzwd_item_t in_item,
    input  logic                 in_valid,
    output logic                 in_ready,
    output lzwd_pkg::lzwd_item_t out_item,
    output logic                 out_valid,
    input  logic                 out_ready
);
    import lzwd_pkg::*;

    lzwd_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    assign in_ready  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    // Pointer wrap and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: sv/lzwd_back.sv
// ----------------------------------------------------------------------------
// lzwd_back
// Execution part: keeps the dictionary, walks a code's prefix chain onto a
// byte stack, adds the new entry and sends the bytes out in string order.
// ----------------------------------------------------------------------------
module lzwd_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  lzwd_pkg::lzwd_item_t        q_item,
    input  logic                        q_valid,
    output logic                        q_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lzwd_pkg::BYTE_W-1:0] m_byte_value,
    output logic [lzwd_pkg::BASE_W-1:0] m_base_0,
    output logic [lzwd_pkg::BASE_W-1:0] m_base_1,
    output logic [lzwd_pkg::BASE_W-1:0] m_base_2,
    output logic [lzwd_pkg::BASE_W-1:0] m_base_3,
    output logic                        m_last,
    output logic                        m_error
);
    import lzwd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_WALK = 5'b00010,
        ST_LIT  = 5'b00100,
        ST_EMIT = 5'b01000,
        ST_ERR  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [SP_W-1:0]   n_reg, n_next;
    logic [CODE_W-1:0] c_reg, c_next;
    logic [CODE_W-1:0] cur_reg, cur_next;
    logic [CODE_W-1:0] prev_reg, prev_next;
    logic [BYTE_W-1:0] prev_first_reg, prev_first_next;
    logic [NFC_W-1:0]  nfc_reg, nfc_next;
    logic              active_reg, active_next;
    logic              hold_reg, hold_next;

    // Byte stack, filled last byte first during the chain walk.
    logic [BYTE_W-1:0] stack_reg [MAX_STRING];
    logic              stack_we;
    logic [SIDX_W-1:0] stack_widx;
    logic [BYTE_W-1:0] stack_wdata;
    logic [SIDX_W-1:0] pop_idx;

    // Dictionary. The first byte of the previous string is kept in a
    // register, so no first-byte table is needed.
    logic [CODE_W-1:0] prefix_mem [DICT_DEPTH];
    logic [BYTE_W-1:0] suffix_mem [DICT_DEPTH];
    logic [CODE_W-1:0] rd_prefix_reg;
    logic [BYTE_W-1:0] rd_suffix_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              dict_we;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_error_reg, out_error_next;
    logic              out_load;

    logic out_free;
    logic dict_room;
    logic code_below;
    logic code_kwk;
    logic prefix_lit;
    logic string_full;

    assign out_free    = !out_valid_reg || m_ready;
    assign dict_room   = 32'(nfc_reg) < DICT_DEPTH;
    assign code_below  = 32'(q_item.code) < 32'(nfc_reg);
    assign code_kwk    = (32'(q_item.code) == 32'(nfc_reg)) && dict_room;
    assign prefix_lit  = rd_prefix_reg < CODE_W'(LITERALS);
    assign string_full = n_reg >= SP_W'(MAX_STRING);
    assign pop_idx     = SIDX_W'(n_reg - 1'b1);

    // Sequencer: dispatch, chain walk, literal and entry update, byte output.
    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        c_next          = c_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_first_next = prev_first_reg;
        nfc_next        = nfc_reg;
        active_next     = active_reg;
        hold_next       = hold_reg;
        q_ready         = 1'b0;
        stack_we        = 1'b0;
        stack_widx      = n_reg[SIDX_W-1:0];
        stack_wdata     = rd_suffix_reg;
        dict_we         = 1'b0;
        rd_addr         = ADDR_W'(rd_prefix_reg);
        out_load        = 1'b0;
        out_valid_next  = out_valid_reg && !m_ready;
        out_byte_next   = '0;
        out_last_next   = 1'b0;
        out_error_next  = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                q_ready = 1'b1;
                rd_addr = ADDR_W'(code_kwk ? prev_reg : q_item.code);
                if (q_valid) begin
                    if (q_item.start) begin
                        // A start clears the dictionary and emits literal or error.
                        nfc_next    = NFC_W'(LITERALS);
                        active_next = 1'b1;
                        hold_next   = !q_item.literal;
                        if (!q_item.literal) begin
                            state_next = ST_ERR;
                        end else begin
                            stack_we        = 1'b1;
                            stack_widx      = '0;
                            stack_wdata     = q_item.code[BYTE_W-1:0];
                            n_next          = SP_W'(1);
                            prev_next       = q_item.code;
                            prev_first_next = q_item.code[BYTE_W-1:0];
                            state_next      = ST_EMIT;
                        end
                    end else if (!active_reg || hold_reg) begin
                        // Ignored item: no result.
                        state_next = ST_IDLE;
                    end else if (q_item.out_of_range) begin
                        hold_next  = 1'b1;
                        state_next = ST_ERR;
                    end else if (code_below) begin
                        n_next     = '0;
                        c_next     = q_item.code;
                        cur_next   = q_item.code;
                        state_next = q_item.literal ? ST_LIT : ST_WALK;
                    end else if (code_kwk) begin
                        // Code not yet defined: previous string plus its first byte.
                        stack_we    = 1'b1;
                        stack_widx  = '0;
                        stack_wdata = prev_first_reg;
                        n_next      = SP_W'(1);
                        c_next      = prev_reg;
                        cur_next    = q_item.code;
                        state_next  = (prev_reg < CODE_W'(LITERALS)) ? ST_LIT : ST_WALK;
                    end else begin
                        hold_next  = 1'b1;
                        state_next = ST_ERR;
                    end
                end
            end
            ST_WALK: begin
                if (string_full) begin
                    hold_next  = 1'b1;
                    state_next = ST_ERR;
                end else begin
                    stack_we = 1'b1;
                    n_next   = n_reg + 1'b1;
                    if (prefix_lit) begin
                        c_next     = rd_prefix_reg;
                        state_next = ST_LIT;
                    end
                end
            end
            ST_LIT: begin
                if (string_full) begin
                    hold_next  = 1'b1;
                    state_next = ST_ERR;
                end else begin
                    stack_we        = 1'b1;
                    stack_wdata     = c_reg[BYTE_W-1:0];
                    n_next          = n_reg + 1'b1;
                    prev_next       = cur_reg;
                    prev_first_next = c_reg[BYTE_W-1:0];
                    if (dict_room) begin
                        dict_we  = 1'b1;
                        nfc_next = nfc_reg + 1'b1;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = stack_reg[pop_idx];
                    out_last_next  = n_reg == SP_W'(1);
                    n_next         = n_reg - 1'b1;
                    if (n_reg == SP_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_error_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            prev_reg      <= '0;
            nfc_reg       <= NFC_W'(LITERALS);
            active_reg    <= 1'b0;
            hold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            prev_reg      <= prev_next;
            nfc_reg       <= nfc_next;
            active_reg    <= active_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge aclk) begin
        c_reg          <= c_next;
        cur_reg        <= cur_next;
        prev_first_reg <= prev_first_next;
        if (stack_we) begin
            stack_reg[stack_widx] <= stack_wdata;
        end
        if (out_load) begin
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
            out_error_reg <= out_error_next;
        end
    end

    // Dictionary memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (dict_we) begin
            prefix_mem[ADDR_W'(nfc_reg)] <= prev_reg;
            suffix_mem[ADDR_W'(nfc_reg)] <= c_reg[BYTE_W-1:0];
        end
        rd_prefix_reg <= prefix_mem[rd_addr];
        rd_suffix_reg <= suffix_mem[rd_addr];
    end

    // Result fields.
    assign m_valid      = out_valid_reg;
    assign m_byte_value = out_byte_reg;
    assign m_base_0     = BASE_W'((out_byte_reg & BASE0_MASK) >> BASE0_SHIFT);
    assign m_base_1     = BASE_W'((out_byte_reg & BASE1_MASK) >> BASE1_SHIFT);
    assign m_base_2     = BASE_W'((out_byte_reg & BASE2_MASK) >> BASE2_SHIFT);
    assign m_base_3     = BASE_W'((out_byte_reg & BASE3_MASK) >> BASE3_SHIFT);
    assign m_last       = out_last_reg;
    assign m_error      = out_error_reg;

    // The stack never holds more than the longest allowed string.
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= SP_W'(MAX_STRING))
        else $error("byte stack overflow");

    // Output only starts from a filled stack.
    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (n_reg != '0))
        else $error("emit with empty stack");

    // The next free code stays between the literals and the dictionary end.
    a_nfc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (nfc_reg >= NFC_W'(LITERALS)) && (32'(nfc_reg) <= DICT_DEPTH))
        else $error("next free code out of range");

    // An error result carries no byte and no last flag.
    a_err_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_error_reg) |-> (out_byte_reg == '0 && !out_last_reg))
        else $error("error result with payload");

    // A chain step always follows a dictionary read issued in the cycle before.
    a_walk_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |->
            ($past(state_reg) == ST_IDLE || $past(state_reg) == ST_WALK))
        else $error("chain walk without prior read");

endmodule

// File: sv/lzw_decode_dna_unpack.sv
// ----------------------------------------------------------------------------
// lzw_decode_dna_unpack
// LZW decoder that emits each decoded byte together with its four DNA bases.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    code[11:0], stream_start
//   m_       out        m_valid/m_ready    byte_value, base_0..3, last, error
//
// A stored code takes one dictionary read per prefix-chain step, one step for the
// root literal, then one byte per cycle while the output is not stalled. Literals
// skip the chain walk, bad codes give one error item and ignored codes give none;
// an overlong string fails once the byte stack is full. Reset is synchronous and active low;
// the dictionary needs no clearing pass. The input stage and a four-item queue
// keep accepting codes while results wait; output stalls hold the current byte.
// ----------------------------------------------------------------------------
module lzw_decode_dna_unpack (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lzwd_pkg::CODE_W-1:0] s_code,
    input  logic                        s_stream_start,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lzwd_pkg::BYTE_W-1:0] m_byte_value,
    output logic [lzwd_pkg::BASE_W-1:0] m_base_0,
    output logic [lzwd_pkg::BASE_W-1:0] m_base_1,
    output logic [lzwd_pkg::BASE_W-1:0] m_base_2,
    output logic [lzwd_pkg::BASE_W-1:0] m_base_3,
    output logic                        m_last,
    output logic                        m_error
);
    import lzwd_pkg::*;

    lzwd_item_t front_item;
    logic       front_valid;
    logic       front_ready;
    lzwd_item_t q_item;
    logic       q_valid;
    logic       q_ready;

    // Input stage with classification.
    lzwd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code         (s_code),
        .s_stream_start (s_stream_start),
        .item           (front_item),
        .item_valid     (front_valid),
        .item_ready     (front_ready)
    );

    // Queue between the two parts.
    lzwd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_item   (front_item),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_item  (q_item),
        .out_valid (q_valid),
        .out_ready (q_ready)
    );

    // Dictionary, chain walk and byte output.
    lzwd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_item       (q_item),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_byte_value (m_byte_value),
        .m_base_0     (m_base_0),
        .m_base_1     (m_base_1),
        .m_base_2     (m_base_2),
        .m_base_3     (m_base_3),
        .m_last       (m_last),
        .m_error      (m_error)
    );

endmodule

// File: bench/lzw_decode_dna_unpack_tb.sv
// ----------------------------------------------------------------------------
// lzw_decode_dna_unpack_tb
// Self-checking bench for the LZW decoder with DNA base unpacking. A tracker
// class keeps its own copy of the dictionary, works out every decoded byte of
// each accepted code and checks the result items in order. Stimulus runs a
// short directed list, long prefix chains and a random mix of well-formed
// streams and noise, with random idling on both channels.
// ----------------------------------------------------------------------------
module lzw_decode_dna_unpack_tb;

    import lzwd_pkg::*;

    localparam int RANDOM_ITEMS = 200;
    localparam int CALM_ITEMS   = 40;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int CODE_MAX     = (1 << CODE_W) - 1;

    // One decoded byte as it leaves the block.
    typedef struct {
        logic [BYTE_W-1:0] value;
        logic [BASE_W-1:0] base0;
        logic [BASE_W-1:0] base1;
        logic [BASE_W-1:0] base2;
        logic [BASE_W-1:0] base3;
        logic              last;
        logic              error;
    } dna_byte_t;

    typedef logic [BYTE_W-1:0] field_set_t [7];

    // Tracks the decoder dictionary and holds the bytes still to come.
    class lzw_byte_tracker;
        logic [CODE_W-1:0] prefix_of [DICT_DEPTH];
        logic [BYTE_W-1:0] suffix_of [DICT_DEPTH];
        int unsigned       free_code;
        logic [CODE_W-1:0] last_code;
        bit                active;
        bit                held;
        logic [BYTE_W-1:0] spelled [$];
        dna_byte_t         expected_bytes [$];
        int                failures;
        int                bytes_checked;
        int                errors_checked;

        function new();
            free_code      = LITERALS;
            last_code      = '0;
            active         = 1'b0;
            held           = 1'b0;
            failures       = 0;
            bytes_checked  = 0;
            errors_checked = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Length of the string of a code that is already in the dictionary.
        function int chain_len(int unsigned c);
            int n;
            n = 1;
            while (c >= LITERALS && n <= MAX_STRING + 1) begin
                c = 32'(prefix_of[c]);
                n++;
            end
            return n;
        endfunction

        // Spells a code into the scratch string; fails if it is too long.
        function bit unwind(int unsigned c);
            spelled = {};
            while (c >= LITERALS) begin
                if (spelled.size() >= MAX_STRING || c >= DICT_DEPTH) return 1'b0;
                spelled.push_front(suffix_of[c]);
                c = 32'(prefix_of[c]);
            end
            if (spelled.size() >= MAX_STRING) return 1'b0;
            spelled.push_front(c[BYTE_W-1:0]);
            return 1'b1;
        endfunction

        function int add_error();
            dna_byte_t r;
            r = '{value: '0, base0: '0, base1: '0, base2: '0, base3: '0,
                  last: 1'b0, error: 1'b1};
            expected_bytes.push_back(r);
            held = 1'b1;
            return 1;
        endfunction

        function int add_string();
            dna_byte_t   r;
            logic [7:0]  b;
            foreach (spelled[i]) begin
                b       = spelled[i];
                r.value = b;
                r.base0 = b[7:6];
                r.base1 = b[5:4];
                r.base2 = b[3:2];
                r.base3 = b[1:0];
                r.last  = (i == spelled.size() - 1);
                r.error = 1'b0;
                expected_bytes.push_back(r);
            end
            return spelled.size();
        endfunction

        // Notes an accepted code and returns how many result items it causes.
        function int note_code(logic [CODE_W-1:0] code, logic start);
            int unsigned c;
            c = 32'(code);
            if (start) begin
                free_code = LITERALS;
                active    = 1'b1;
                held      = 1'b0;
                if (c >= LITERALS) return add_error();
                last_code = code;
                spelled   = {code[BYTE_W-1:0]};
                return add_string();
            end
            if (!active || held) return 0;
            if (c >= DICT_DEPTH) return add_error();
            if (c < free_code) begin
                if (!unwind(c)) return add_error();
            end else if (c == free_code && free_code < DICT_DEPTH) begin
                // Code not yet in the dictionary: previous string plus its head.
                if (!unwind(32'(last_code)) || spelled.size() >= MAX_STRING)
                    return add_error();
                spelled.push_back(spelled[0]);
            end else begin
                return add_error();
            end
            // Once the dictionary is full no further entries are made.
            if (free_code < DICT_DEPTH) begin
                prefix_of[free_code] = last_code;
                suffix_of[free_code] = spelled[0];
                free_code++;
            end
            last_code = code;
            return add_string();
        endfunction

        function field_set_t fields_of(dna_byte_t r);
            field_set_t f;
            f = '{r.value, 8'(r.base0), 8'(r.base1), 8'(r.base2), 8'(r.base3),
                  8'(r.last), 8'(r.error)};
            return f;
        endfunction

        // Compares one result item with the oldest expected byte.
        function void check_byte(dna_byte_t got);
            dna_byte_t  want;
            field_set_t e;
            field_set_t a;
            string      names [7];
            names = '{"byte_value", "base_0", "base_1", "base_2", "base_3", "last",
                      "error"};
            if (expected_bytes.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, actual byte %0h error %0b",
                         $time, got.value, got.error);
                return;
            end
            want = expected_bytes.pop_front();
            if (want.error) errors_checked++;
            else bytes_checked++;
            e = fields_of(want);
            a = fields_of(got);
            for (int i = 0; i < 7; i++) begin
                if (e[i] !== a[i]) begin
                    failures++;
                    $display("%0t: mismatch on %s, expected %0h, actual %0h",
                             $time, names[i], e[i], a[i]);
                end
            end
        endfunction
    endclass

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [CODE_W-1:0] s_code         = '0;
    logic              s_stream_start = 1'b0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [BYTE_W-1:0] m_byte_value;
    logic [BASE_W-1:0] m_base_0;
    logic [BASE_W-1:0] m_base_1;
    logic [BASE_W-1:0] m_base_2;
    logic [BASE_W-1:0] m_base_3;
    logic              m_last;
    logic              m_error;

    lzw_byte_tracker tracker;
    bit              calm          = 1'b0;
    bit              sender_quiet  = 1'b0;
    int              codes_taken   = 0;
    int              cycle_count   = 0;

    lzw_decode_dna_unpack uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code         (s_code),
        .s_stream_start (s_stream_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_value   (m_byte_value),
        .m_base_0       (m_base_0),
        .m_base_1       (m_base_1),
        .m_base_2       (m_base_2),
        .m_base_3       (m_base_3),
        .m_last         (m_last),
        .m_error        (m_error)
    );

    // Clock generation.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Check every result item taken at a clock edge.
    always @(posedge aclk) begin
        dna_byte_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{value: m_byte_value, base0: m_base_0, base1: m_base_1,
                    base2: m_base_2, base3: m_base_3, last: m_last, error: m_error};
            tracker.check_byte(got);
        end
    end

    // Result side back-pressure in random bursts.
    initial begin : ready_bursts
        int span;
        @(posedge aclk);
        forever begin
            if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if ($urandom_range(0, 2) == 0) begin
                span = $urandom_range(1, 8);
                m_ready <= 1'b0;
                repeat (span) @(posedge aclk);
            end else begin
                span = $urandom_range(1, 24);
                m_ready <= 1'b1;
                repeat (span) @(posedge aclk);
            end
        end
    end

    // Offers one code, waits for it to be taken and notes it.
    task automatic send_code(input logic [CODE_W-1:0] code, input logic start,
                             output int produced);
        int gap;
        if (!calm && !sender_quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_code         <= code;
        s_stream_start <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        produced = tracker.note_code(code, start);
        codes_taken++;
    endtask

    // Holds the sender off until every expected byte has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    // A run of codes that each extend the previous string by one byte.
    task automatic grow_chain(input logic [7:0] head);
        int n;
        send_code(12'(head), 1'b1, n);
        for (int c = LITERALS; c < LITERALS + MAX_STRING - 1; c++) send_code(12'(c), 1'b0, n);
    endtask

    initial begin : stimulus
        int          n;
        int          roll;
        int          tries;
        logic [CODE_W-1:0] code;
        logic        start;
        int unsigned pick;

        tracker = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle and held codes, bad first code, literal extremes,
        // a known entry, the not-yet-defined code and codes past the end.
        send_code(12'd5, 1'b0, n);
        send_code(12'd300, 1'b1, n);
        send_code(12'd10, 1'b0, n);
        send_code(12'h000, 1'b1, n);
        send_code(12'h0FF, 1'b0, n);
        send_code(12'd256, 1'b0, n);
        send_code(12'd258, 1'b0, n);
        send_code(12'h055, 1'b0, n);
        send_code(12'h0AA, 1'b0, n);
        send_code(12'h01B, 1'b0, n);
        send_code(12'h0E4, 1'b0, n);
        send_code(12'd300, 1'b0, n);
        send_code(12'd4095, 1'b0, n);
        send_code(12'h0FF, 1'b1, n);
        send_code(12'd4095, 1'b0, n);
        send_code(12'h03C, 1'b1, n);
        send_code(12'd256, 1'b0, n);
        send_code(12'd257, 1'b0, n);
        send_code(12'd256, 1'b0, n);
        wait_drained();

        // Longest strings, then an overlong stored entry and an overlong
        // extension of the previous string.
        grow_chain(8'h41);
        send_code(12'h042, 1'b0, n);
        send_code(12'(LITERALS + MAX_STRING - 1), 1'b0, n);
        grow_chain(8'hC3);
        send_code(12'(LITERALS + MAX_STRING - 1), 1'b0, n);
        wait_drained();

        // Random part: mostly well-formed streams, some noise and bad starts.
        codes_taken = 0;
        for (int k = 0; k < RANDOM_ITEMS; ) begin
            if (k % 32 == 0) sender_quiet = ($urandom_range(0, 2) == 0);
            if (k >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            roll  = $urandom_range(0, 99);
            start = 1'b0;
            if (roll < 4) begin
                start = 1'b1;
                code  = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 255))
                                                    : 12'($urandom_range(0, CODE_MAX));
            end else if (roll < 9) begin
                start = 1'($urandom_range(0, 1));
                code  = 12'($urandom_range(0, CODE_MAX));
            end else if (!tracker.active || tracker.held) begin
                start = 1'b1;
                code  = 12'($urandom_range(0, 255));
            end else if (roll < 35) begin
                code = 12'($urandom_range(0, 255));
            end else if (roll < 55 && tracker.free_code < DICT_DEPTH &&
                         tracker.chain_len(32'(tracker.last_code)) < MAX_STRING) begin
                code = 12'(tracker.free_code);
            end else begin
                code = 12'($urandom_range(0, 255));
                if (tracker.free_code > LITERALS) begin
                    for (tries = 0; tries < 4; tries++) begin
                        pick = $urandom_range(LITERALS, tracker.free_code - 1);
                        if (tracker.chain_len(pick) <= MAX_STRING) begin
                            code = 12'(pick);
                            break;
                        end
                    end
                end
            end
            send_code(code, start, n);
            if (n > 0) k++;
            if (!calm && $urandom_range(0, 49) == 0) wait_drained();
        end
        s_valid <= 1'b0;

        // Let the last bytes come out, then allow time for stray items.
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered: directed codes, strings up to %0d bytes and %0d random codes.",
                 MAX_STRING, codes_taken);
        $display("Checked %0d decoded bytes and %0d error items, %0d mismatches.",
                 tracker.bytes_checked, tracker.errors_checked, tracker.failures);
        if (tracker.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: lzw_decode_dna_unpack.f
sv/lzwd_pkg.sv
sv/lzwd_front.sv
sv/lzwd_queue.sv
sv/lzwd_back.sv
sv/lzw_decode_dna_unpack.sv
bench/lzw_decode_dna_unpack_tb.sv
